// File: rtl/pcg32_ranged_random_generator_macros.svh
// Assertion macros for the checker of the ranged PCG32 generator.
// Expects clk and rst_n in scope where a macro is used.
`ifndef PCG32_RANGED_RANDOM_GENERATOR_MACROS_SVH
`define PCG32_RANGED_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define PCG32_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcg32 check failed");

// Next-cycle implication.
`define PCG32_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcg32 check failed");

`endif

// File: rtl/pcg32_pkg.sv
// Shared constants, codes and types of the ranged PCG32 generator.
// No dependencies.
package pcg32_pkg;

  localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
  localparam logic [63:0] PCG_INC  = 64'd105;
  localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
  localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];
  // State after seeding with zero: 0 -> 105 -> 105*M + 105.
  localparam logic [63:0] PCG_RESET_STATE = PCG_INC * PCG_MULT + PCG_INC;

  // Request kinds
  localparam logic [1:0] CMD_SEED  = 2'd0;
  localparam logic [1:0] CMD_FRAC  = 2'd1;
  localparam logic [1:0] CMD_UPPER = 2'd2;
  localparam logic [1:0] CMD_RANGE = 2'd3;

  // Result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_LARGE = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL_LL,
    SEQ_MUL_HL,
    SEQ_MUL_LH,
    SEQ_SUM,
    SEQ_RNG,
    SEQ_DONE
  } seq_state_t;

endpackage

// File: rtl/pcg32_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// No package dependencies.
module pcg32_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= {32'd0, a} * {32'd0, b};
    end
  end

  assign p = p_r;

endmodule

// File: rtl/pcg32_ranged_random_generator.sv
// Ranged PCG32 (XSH-RR) random generator, sequenced over one shared 32x32 multiplier.
// Depends on pcg32_pkg and pcg32_mul.
//
// Usage:
//   Input channel in_*: one request per handshake. in_tuser carries the request kind
//   (seed, fraction draw, draw 1..upper, draw lower..upper); in_tdata carries the
//   bounds and the seed. Output channel out_*: one result per draw request, none for
//   a seed. out_tuser carries the status, out_tdata the fraction and integer draw.
//   One generator step is three 32x32 partial products on the shared multiplier plus
//   a sum state. A seed takes one step, a fraction draw two steps, a ranged draw one
//   step plus the span multiply; a rejected interval skips the multiplier.
//   The result is registered in the output register as the sequencer leaves its
//   final state. in_tready is high only while the sequencer is idle.
//   A finished result sits in the output register; the next request is accepted
//   while it waits, and the sequencer holds in its final state only if a second
//   result is ready before the first is taken.
//   Reset (rst_n low, synchronous) empties the output, idles the sequencer and
//   loads the state reached by seeding with zero.
module pcg32_ranged_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] lower_bound, [63:32] upper_bound, [95:64] seed_value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [63:0] fraction, [95:64] integer_draw
  output logic [1:0]  out_tuser   // [1:0] status
);
  import pcg32_pkg::*;

  seq_state_t  fsm_r, fsm_nxt;
  logic [63:0] state_r;      // generator state
  logic [63:0] acc_r;        // partial sum of state * multiplier
  logic [63:0] frac_r;       // captured output words, low word first
  logic [31:0] span_r;       // multiplier for the ranged draw
  logic [31:0] base_r;       // offset added to the high product word
  logic [1:0]  cmd_r;
  logic [1:0]  status_r;
  logic        pass_r;       // second step of a fraction draw
  logic [95:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_valid_r;

  logic        in_fire;
  logic        out_free;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [1:0]  in_cmd;
  logic [31:0] in_lo, in_hi, in_seed;
  logic [31:0] in_span;
  logic [1:0]  in_status;

  logic [31:0] mixed;
  logic [63:0] mixed2;
  logic [31:0] word;

  assign in_cmd  = in_tuser;
  assign in_lo   = in_tdata[31:0];
  assign in_hi   = in_tdata[63:32];
  assign in_seed = in_tdata[95:64];
  assign in_span = in_hi - in_lo;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Interval checks at acceptance
  always_comb begin
    in_status = STAT_OK;
    unique case (in_cmd)
      CMD_UPPER: begin
        if ($signed(in_hi) < 32'sd1) in_status = STAT_EMPTY;
      end
      CMD_RANGE: begin
        if ($signed(in_lo) > $signed(in_hi)) in_status = STAT_EMPTY;
        else if (in_span == 32'hFFFF_FFFF) in_status = STAT_LARGE;
      end
      default: in_status = STAT_OK;
    endcase
  end

  // XSH-RR output of the current (old) state
  assign mixed  = 32'(((state_r >> 18) ^ state_r) >> 27);
  assign mixed2 = {mixed, mixed} >> state_r[63:59];
  assign word   = mixed2[31:0];

  pcg32_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Next state
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      SEQ_IDLE: begin
        if (in_fire) fsm_nxt = (in_status != STAT_OK) ? SEQ_DONE : SEQ_MUL_LL;
      end
      SEQ_MUL_LL: fsm_nxt = SEQ_MUL_HL;
      SEQ_MUL_HL: fsm_nxt = SEQ_MUL_LH;
      SEQ_MUL_LH: fsm_nxt = SEQ_SUM;
      SEQ_SUM: begin
        unique case (cmd_r)
          CMD_SEED:  fsm_nxt = SEQ_IDLE;
          CMD_FRAC:  fsm_nxt = pass_r ? SEQ_DONE : SEQ_MUL_LL;
          default:   fsm_nxt = SEQ_RNG;
        endcase
      end
      SEQ_RNG:  fsm_nxt = SEQ_DONE;
      SEQ_DONE: begin
        if (out_free) fsm_nxt = SEQ_IDLE;
      end
      default:  fsm_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operand select and input ready
  always_comb begin
    in_tready = 1'b0;
    mul_en    = 1'b0;
    mul_a     = state_r[31:0];
    mul_b     = PCG_MULT_LO;
    unique case (fsm_r)
      SEQ_IDLE:   in_tready = 1'b1;
      SEQ_MUL_LL: mul_en = 1'b1;
      SEQ_MUL_HL: begin
        mul_en = 1'b1;
        mul_a  = state_r[63:32];
      end
      SEQ_MUL_LH: begin
        mul_en = 1'b1;
        mul_b  = PCG_MULT_HI;
      end
      SEQ_RNG: begin
        mul_en = 1'b1;
        mul_a  = span_r;
        mul_b  = frac_r[31:0];
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= SEQ_IDLE;
      state_r     <= PCG_RESET_STATE;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      // Output register: filled by the sequencer, emptied once taken.
      if (fsm_r == SEQ_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)               out_valid_r <= 1'b0;

      unique case (fsm_r)
        SEQ_IDLE: begin
          if (in_fire) begin
            cmd_r    <= in_cmd;
            status_r <= in_status;
            pass_r   <= 1'b0;
            frac_r   <= 64'd0;
            if (in_cmd == CMD_RANGE) begin
              span_r <= in_span + 32'd1;
              base_r <= in_lo;
            end else begin
              span_r <= in_hi;
              base_r <= 32'd1;
            end
            // First step from a cleared state always lands on the increment.
            if (in_cmd == CMD_SEED) begin
              state_r <= PCG_INC + {{32{in_seed[31]}}, in_seed};
            end
          end
        end
        SEQ_MUL_LL: begin
          if (pass_r) frac_r[63:32] <= word;
          else        frac_r[31:0]  <= word;
        end
        SEQ_MUL_HL: acc_r <= mul_p;
        SEQ_MUL_LH: acc_r <= acc_r + {mul_p[31:0], 32'd0};
        SEQ_SUM: begin
          state_r <= acc_r + {mul_p[31:0], 32'd0} + PCG_INC;
          pass_r  <= 1'b1;
        end
        SEQ_DONE: begin
          if (out_free) begin
            out_user_r  <= status_r;
            out_data_r[63:0] <= (cmd_r == CMD_FRAC) ? frac_r : 64'd0;
            out_data_r[95:64] <= (status_r == STAT_OK && cmd_r != CMD_FRAC)
                                 ? base_r + mul_p[63:32] : 32'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/pcg32_sva.sv
// Port-level checker for the ranged PCG32 generator, bound to the top level.
// Depends on pcg32_pkg and pcg32_ranged_random_generator_macros.svh.
`include "pcg32_ranged_random_generator_macros.svh"

module pcg32_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import pcg32_pkg::*;

  // Result held while stalled
  `PCG32_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // An accepted request takes the sequencer out of idle and drops in_tready
  `PCG32_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  // Rejected intervals carry no draw
  `PCG32_ASSERT_IMPL(a_err_zero, out_tvalid && out_tuser != STAT_OK, out_tdata == 96'd0)
  // Only defined status codes leave the block
  `PCG32_ASSERT_IMPL(a_status_code, out_tvalid,
                     out_tuser == STAT_OK || out_tuser == STAT_EMPTY || out_tuser == STAT_LARGE)

endmodule

bind pcg32_ranged_random_generator pcg32_sva u_pcg32_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
